// File: design/rap_pkg.sv
package rap_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int PRESSURE_W = 32;
    localparam int WL_W       = 6;
    localparam int OFFSET_W   = 16;
    localparam int GAIN_W     = 32;
    localparam int FRAC_BITS  = 16;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COUNTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;

    // Register reset values
    localparam logic [WL_W-1:0]     RST_WINDOW_LENGTH = 6'd8;
    localparam logic [OFFSET_W-1:0] RST_OFFSET_COUNTS = 16'd0;
    localparam logic [GAIN_W-1:0]   RST_GAIN          = 32'h0001_0000;

    // Parameter defaults
    localparam int DEF_MAX_WINDOW  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

endpackage

// File: design/rap_if.sv
interface rap_sample_if;
    import rap_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rap_result_if;
    import rap_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [PRESSURE_W-1:0] pressure;
    logic [AVG_W-1:0]             average_counts;
    logic                         window_full;

    modport source (output valid, output pressure, output average_counts,
                    output window_full, input ready);
    modport sink   (input valid, input pressure, input average_counts,
                    input window_full, output ready);
endinterface

interface rap_cfg_if;
    import rap_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/rap_ram.sv
module rap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/rap_div.sv
module rap_div #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  take;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial     = {r_rem, r_quo[DIVIDEND_W-1]};
        trial_sub = trial - {1'b0, r_div};
        take      = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
            r_rem <= take ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// File: design/rolling_average_pressure_unit.sv
// Rolling-average pressure scaler.
// Channels: i_in carries one raw ADC sample per request, o_out returns one
// result per sample (scaled pressure, windowed average in counts and a
// window-full flag), i_cfg writes the window length, zero offset and Q16.16
// gain by register index. i_cfg is always ready; write it only while idle.
// Samples sit in a ring memory with a running sum beside it. Each sample
// passes through these steps in order: read the oldest entry, update sum,
// ring and pointers, run the SUM_W-bit serial divider (SUM_W = SAMPLE_BITS +
// log2(MAX_WINDOW), 21 at the defaults), multiply, and load the output
// register. The bit-serial divide by the fill count takes the most time.
// One sample is in flight at a time; i_in is ready again once the result
// has moved into the output register, even if o_out has not yet taken it.
// A stalled o_out holds its result; a finished sample waits there until
// the register frees.
// Reset (i_rst_n low at a clock edge) empties the window and sets the window
// length to 8, offset to 0 and gain to 1.0. Writing the window length
// restarts warm-up; ring contents need no clearing.
module rolling_average_pressure_unit #(
    parameter int MAX_WINDOW  = rap_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = rap_pkg::DEF_SAMPLE_BITS
) (
    input logic           i_clk,
    input logic           i_rst_n,
    rap_sample_if.sink    i_in,
    rap_result_if.source  o_out,
    rap_cfg_if.sink       i_cfg
);
    import rap_pkg::*;

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CMP_W  = (LEN_W > WL_W) ? LEN_W : WL_W;
    localparam int DIFF_W = OFFSET_W + 1;
    localparam int PROD_W = DIFF_W + GAIN_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;

    // Configuration registers
    logic [WL_W-1:0]     r_window_length;
    logic [OFFSET_W-1:0] r_offset;
    logic [GAIN_W-1:0]   r_gain;

    // Window state
    t_state              r_state;
    t_state              n_state;
    logic [PTR_W-1:0]    r_wptr;
    logic [PTR_W-1:0]    n_wptr;
    logic [LEN_W-1:0]    r_fill;
    logic [LEN_W-1:0]    n_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic                r_full;
    logic                n_full;

    // Datapath
    logic [SAMPLE_BITS-1:0]   r_sample;
    logic [AVG_W-1:0]         r_avg;
    logic signed [PROD_W-1:0] r_prod;

    // Output register
    logic                         r_out_valid;
    logic signed [PRESSURE_W-1:0] r_pressure;
    logic [AVG_W-1:0]             r_out_avg;
    logic                         r_out_full;

    logic [LEN_W-1:0]         eff_len;
    logic [CMP_W-1:0]         wl_ext;
    logic [LEN_W-1:0]         ptr_inc;
    logic                     was_full;
    logic [SAMPLE_BITS-1:0]   ring_rdata;
    logic                     ring_we;
    logic                     in_take;
    logic                     out_load;
    logic                     cfg_take;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SH_W-1:0]   shifted;
    logic signed [PRESSURE_W-1:0] sat_pressure;

    rap_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wptr),
        .i_wdata (r_sample),
        .i_raddr (r_wptr),
        .o_rdata (ring_rdata)
    );

    rap_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Clamp the window length to 1..MAX_WINDOW
    always_comb begin
        wl_ext = CMP_W'(r_window_length);
        if (r_window_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(wl_ext);
        end
    end

    // Ring update: drop the oldest sample once full, add the new one
    always_comb begin
        was_full = (r_fill >= eff_len);
        ptr_inc  = LEN_W'(r_wptr) + LEN_W'(1);
        n_sum    = r_sum - (was_full ? SUM_W'(ring_rdata) : SUM_W'(0))
                   + SUM_W'(r_sample);
        n_fill   = was_full ? r_fill : r_fill + LEN_W'(1);
        n_full   = (n_fill >= eff_len);
        n_wptr   = (ptr_inc >= eff_len) ? '0 : PTR_W'(ptr_inc);
    end

    // Scale: floor shift of the product, saturate to 32 bits
    always_comb begin
        diff    = $signed({1'b0, r_avg}) - $signed({1'b0, r_offset});
        shifted = r_prod[PROD_W-1:FRAC_BITS];
        if ((&shifted[SH_W-1:PRESSURE_W-1]) || !(|shifted[SH_W-1:PRESSURE_W-1])) begin
            sat_pressure = shifted[PRESSURE_W-1:0];
        end else if (shifted[SH_W-1]) begin
            sat_pressure = {1'b1, {(PRESSURE_W-1){1'b0}}};
        end else begin
            sat_pressure = {1'b0, {(PRESSURE_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state   = r_state;
        in_take   = 1'b0;
        ring_we   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    in_take = 1'b1;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                ring_we   = 1'b1;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign cfg_take = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= RST_WINDOW_LENGTH;
            r_offset        <= RST_OFFSET_COUNTS;
            r_gain          <= RST_GAIN;
            r_wptr          <= '0;
            r_fill          <= '0;
            r_sum           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_state == S_UPDATE) begin
                r_wptr <= n_wptr;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_take) begin
                unique case (i_cfg.index)
                    CFG_WINDOW_LENGTH: begin
                        r_window_length <= i_cfg.data[WL_W-1:0];
                        r_wptr          <= '0;
                        r_fill          <= '0;
                        r_sum           <= '0;
                    end
                    CFG_OFFSET_COUNTS: r_offset <= i_cfg.data[OFFSET_W-1:0];
                    CFG_GAIN:          r_gain   <= i_cfg.data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= i_in.sample[SAMPLE_BITS-1:0];
        end
        if (r_state == S_UPDATE) begin
            r_full <= n_full;
        end
        if (r_state == S_DIV && div_done) begin
            r_avg <= AVG_W'(div_quo[SAMPLE_BITS-1:0]);
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(diff) * PROD_W'($signed(r_gain));
        end
        if (out_load) begin
            r_pressure <= sat_pressure;
            r_out_avg  <= r_avg;
            r_out_full <= r_full;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.pressure       = r_pressure;
    assign o_out.average_counts = r_out_avg;
    assign o_out.window_full    = r_out_full;

`ifndef SYNTH
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_len)
        else $error("fill count beyond window length");

    a_wptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(r_wptr) < eff_len)
        else $error("write pointer beyond window length");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside divide state");

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out.valid)
        else $error("result loaded but not presented");
`endif
endmodule
